// ----- rtl/core/gsbc_pkg.sv -----
// Shared types, constants and the micro-program of the single-bin Goertzel unit.
package gsbc_pkg;

  // Coefficient format and rounding shifts.
  localparam int COEF_WIDTH = 18;
  localparam int FB_SHIFT   = 15;
  localparam int OUT_SHIFT  = 16;

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN = 1'b1;

  // Coefficient reset values: cos = 1.0, sin = 0.0 in Q1.16.
  localparam logic signed [COEF_WIDTH-1:0] COS_RESET = 18'sd65536;
  localparam logic signed [COEF_WIDTH-1:0] SIN_RESET = 18'sd0;

  // Micro-program sequencing.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] FB_LAST_STEP  = 5'd10;
  localparam logic [STEP_W-1:0] OUT_LAST_STEP = 5'd28;

  typedef enum logic [2:0] {
    OP_MUL_LO,
    OP_MUL_HI,
    OP_RND,
    OP_ALU,
    OP_SHIFT,
    OP_CLEAR
  } uop_op_e;

  typedef enum logic {
    A_PREV_R,
    A_PREV_I
  } a_sel_e;

  typedef enum logic {
    C_COS,
    C_SIN
  } c_sel_e;

  typedef enum logic {
    X_PROD,
    X_ACC
  } x_sel_e;

  typedef enum logic [2:0] {
    Y_PREV2_R,
    Y_PREV2_I,
    Y_SMP_R,
    Y_SMP_I,
    Y_PROD,
    Y_ZERO
  } y_sel_e;

  typedef enum logic [2:0] {
    D_ACC,
    D_NR,
    D_NI,
    D_RE,
    D_IM
  } dst_e;

  typedef struct packed {
    uop_op_e op;
    a_sel_e  a_sel;
    c_sel_e  c_sel;
    logic    rnd_out;
    x_sel_e  x_sel;
    y_sel_e  y_sel;
    logic    sub;
    dst_e    dst;
  } uop_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    uop_t uop;
  } dp_cmd_t;

  localparam uop_t UOP_NONE = '{
    op:      OP_ALU,
    a_sel:   A_PREV_R,
    c_sel:   C_COS,
    rnd_out: 1'b0,
    x_sel:   X_ACC,
    y_sel:   Y_ZERO,
    sub:     1'b0,
    dst:     D_ACC
  };

  function automatic uop_t mul_uop(uop_op_e op, a_sel_e a, c_sel_e c);
    uop_t u;
    u       = UOP_NONE;
    u.op    = op;
    u.a_sel = a;
    u.c_sel = c;
    return u;
  endfunction

  function automatic uop_t rnd_uop(logic out_scale);
    uop_t u;
    u         = UOP_NONE;
    u.op      = OP_RND;
    u.rnd_out = out_scale;
    return u;
  endfunction

  function automatic uop_t alu_uop(x_sel_e x, y_sel_e y, logic sub, dst_e dst);
    uop_t u;
    u       = UOP_NONE;
    u.op    = OP_ALU;
    u.x_sel = x;
    u.y_sel = y;
    u.sub   = sub;
    u.dst   = dst;
    return u;
  endfunction

  function automatic uop_t ctl_uop(uop_op_e op);
    uop_t u;
    u    = UOP_NONE;
    u.op = op;
    return u;
  endfunction

  // Steps 0 to 10 run the recurrence of both lanes; steps 11 to 28 form the bin.
  function automatic uop_t uop_rom(logic [STEP_W-1:0] step);
    uop_t u;
    u = UOP_NONE;
    unique case (step)
      5'd0:  u = mul_uop(OP_MUL_LO, A_PREV_R, C_COS);
      5'd1:  u = mul_uop(OP_MUL_HI, A_PREV_R, C_COS);
      5'd2:  u = rnd_uop(1'b0);
      5'd3:  u = alu_uop(X_PROD, Y_PREV2_R, 1'b1, D_ACC);
      5'd4:  u = alu_uop(X_ACC, Y_SMP_R, 1'b0, D_NR);
      5'd5:  u = mul_uop(OP_MUL_LO, A_PREV_I, C_COS);
      5'd6:  u = mul_uop(OP_MUL_HI, A_PREV_I, C_COS);
      5'd7:  u = rnd_uop(1'b0);
      5'd8:  u = alu_uop(X_PROD, Y_PREV2_I, 1'b1, D_ACC);
      5'd9:  u = alu_uop(X_ACC, Y_SMP_I, 1'b0, D_NI);
      5'd10: u = ctl_uop(OP_SHIFT);
      5'd11: u = mul_uop(OP_MUL_LO, A_PREV_R, C_COS);
      5'd12: u = mul_uop(OP_MUL_HI, A_PREV_R, C_COS);
      5'd13: u = rnd_uop(1'b1);
      5'd14: u = alu_uop(X_PROD, Y_PREV2_R, 1'b1, D_ACC);
      5'd15: u = mul_uop(OP_MUL_LO, A_PREV_I, C_SIN);
      5'd16: u = mul_uop(OP_MUL_HI, A_PREV_I, C_SIN);
      5'd17: u = rnd_uop(1'b1);
      5'd18: u = alu_uop(X_ACC, Y_PROD, 1'b1, D_RE);
      5'd19: u = mul_uop(OP_MUL_LO, A_PREV_R, C_SIN);
      5'd20: u = mul_uop(OP_MUL_HI, A_PREV_R, C_SIN);
      5'd21: u = rnd_uop(1'b1);
      5'd22: u = alu_uop(X_PROD, Y_ZERO, 1'b0, D_ACC);
      5'd23: u = mul_uop(OP_MUL_LO, A_PREV_I, C_COS);
      5'd24: u = mul_uop(OP_MUL_HI, A_PREV_I, C_COS);
      5'd25: u = rnd_uop(1'b1);
      5'd26: u = alu_uop(X_ACC, Y_PROD, 1'b0, D_ACC);
      5'd27: u = alu_uop(X_ACC, Y_PREV2_I, 1'b1, D_IM);
      5'd28: u = ctl_uop(OP_CLEAR);
      default: u = UOP_NONE;
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/core/goertzel_single_bin_complex_unit.sv -----
// Top level of the single-bin complex Goertzel unit: controller, datapath and checks.
//
// Computes one DFT bin over a block of complex samples with two Goertzel recurrences, one
// for the real and one for the imaginary part, sharing 2*cos(omega). Write cos and sin of
// omega as signed Q1.16 values to registers 0 and 1 while the unit is idle. Each sample
// is transferred and then runs 11 micro-operations of the recurrence; the sample marked
// last then runs the bin steps, which wait while a previous bin still waits in the result
// register. The pace is set by the single shared multiplier, which forms each
// lane-times-coefficient product as two ACC_WIDTH/2 by 18 bit partial products followed
// by a rounding step, and by the micro-program that runs all products through it in turn.
// After the bin is formed the lane state clears and the next block may start; a finished
// bin waits in the output register while the next block's samples are taken.
module goertzel_single_bin_complex_unit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gsbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gsbc_pkg::COEF_WIDTH-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_im_i,
  input  logic                             last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [ACC_WIDTH-1:0]      bin_real_o,
  output logic signed [ACC_WIDTH-1:0]      bin_imag_o
);
  import gsbc_pkg::*;

  dp_cmd_t cmd;

  // Sequencer and handshakes.
  gsbc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cmd_o         (cmd)
  );

  // Arithmetic and state.
  gsbc_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .bin_real_o  (bin_real_o),
    .bin_imag_o  (bin_imag_o)
  );

  // No micro-operation runs while the unit offers to take a sample.
  a_no_exec_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.exec)
    else $error("micro-operation issued while input is ready");

  // A new bin is presented only right after the clearing step.
  a_valid_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.exec && (cmd.uop.op == OP_CLEAR)))
    else $error("result presented without completing the bin sequence");

  // The result register is never overwritten while a bin waits for transfer.
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec && (cmd.uop.op == OP_ALU) && ((cmd.uop.dst == D_RE) || (cmd.uop.dst == D_IM)))
      |-> !out_valid_o)
    else $error("result register written while a bin is pending");

endmodule

// ----- rtl/core/gsbc_ctrl.sv -----
// Controller: handshakes and micro-program sequencer of the Goertzel unit.
module gsbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              last_sample_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gsbc_pkg::dp_cmd_t cmd_o
);
  import gsbc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic                capture;
  logic                out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign capture     = in_valid_i && in_ready_o;

  // The result register can take a new bin once the pending one is transferred.
  assign out_free = !out_valid_q || out_ready_i;

  // Commands to the datapath.
  assign cmd_o.capture = capture;
  assign cmd_o.exec    = (state_q == ST_RUN);
  assign cmd_o.uop     = uop_rom(step_q);

  // Sequencer: recurrence steps for every sample, bin steps after the last one.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (capture) begin
          state_d = ST_RUN;
          step_d  = '0;
          last_d  = last_sample_i;
        end
      end
      ST_RUN: begin
        if (step_q == FB_LAST_STEP) begin
          step_d = step_q + 1'b1;
          if (!last_q) begin
            state_d = ST_IDLE;
          end else if (!out_free) begin
            state_d = ST_WAIT;
          end
        end else if (step_q == OUT_LAST_STEP) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/gsbc_dp.sv -----
// Datapath: lane state, coefficients, split multiplier, rounding and saturating adder.
module gsbc_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gsbc_pkg::dp_cmd_t                     cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [gsbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gsbc_pkg::COEF_WIDTH-1:0]       cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_im_i,
  output logic signed [ACC_WIDTH-1:0]           bin_real_o,
  output logic signed [ACC_WIDTH-1:0]           bin_imag_o
);
  import gsbc_pkg::*;

  localparam int LO_W = ACC_WIDTH / 2;
  localparam int HI_W = ACC_WIDTH - LO_W;
  localparam int PRW  = ACC_WIDTH + COEF_WIDTH + 1;
  localparam int SW   = ACC_WIDTH + 1;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [PRW-1:0] PR_MAX  = PRW'(ACC_MAX);
  localparam logic signed [PRW-1:0] PR_MIN  = PRW'(ACC_MIN);
  localparam logic signed [SW-1:0]  SUM_MAX = SW'(ACC_MAX);
  localparam logic signed [SW-1:0]  SUM_MIN = SW'(ACC_MIN);
  localparam logic signed [PRW-1:0] HALF_FB  = PRW'(2 ** (FB_SHIFT - 1));
  localparam logic signed [PRW-1:0] HALF_OUT = PRW'(2 ** (OUT_SHIFT - 1));

  logic signed [COEF_WIDTH-1:0]       cos_q, sin_q;
  logic signed [ACC_WIDTH-1:0]        prev_r_q, prev2_r_q, prev_i_q, prev2_i_q;
  logic signed [SAMPLE_WIDTH-1:0]     smp_re_q, smp_im_q;
  logic signed [LO_W+COEF_WIDTH:0]    pp_lo_q, pp_lo_d;
  logic signed [HI_W+COEF_WIDTH-1:0]  pp_hi_q, pp_hi_d;
  logic signed [ACC_WIDTH-1:0]        prod_q, prod_d;
  logic signed [ACC_WIDTH-1:0]        acc_q, nr_q, ni_q;
  logic signed [ACC_WIDTH-1:0]        bin_real_q, bin_imag_q;

  logic signed [ACC_WIDTH-1:0]        a_op;
  logic        [LO_W-1:0]             a_lo;
  logic signed [HI_W-1:0]             a_hi;
  logic signed [COEF_WIDTH-1:0]       c_op;
  logic signed [PRW-1:0]              rnd_sum, rnd_shift;
  logic signed [ACC_WIDTH-1:0]        x_op, y_op;
  logic signed [SW-1:0]               alu_sum;
  logic signed [ACC_WIDTH-1:0]        alu_res;

  uop_t uop;
  assign uop = cmd_i.uop;

  assign bin_real_o = bin_real_q;
  assign bin_imag_o = bin_imag_q;

  // Multiplier operands: one lane value times one coefficient.
  assign a_op = (uop.a_sel == A_PREV_R) ? prev_r_q : prev_i_q;
  assign c_op = (uop.c_sel == C_COS) ? cos_q : sin_q;
  assign a_lo = a_op[LO_W-1:0];
  assign a_hi = a_op[ACC_WIDTH-1:LO_W];

  // Partial products: the low half is unsigned, the high half carries the sign.
  assign pp_lo_d = $signed({1'b0, a_lo}) * c_op;
  assign pp_hi_d = a_hi * c_op;

  // Recombine, round to nearest with ties up, and saturate to the lane width.
  assign rnd_sum   = (PRW'(pp_hi_q) <<< LO_W) + PRW'(pp_lo_q)
                   + (uop.rnd_out ? HALF_OUT : HALF_FB);
  assign rnd_shift = uop.rnd_out ? (rnd_sum >>> OUT_SHIFT) : (rnd_sum >>> FB_SHIFT);

  always_comb begin
    if (rnd_shift > PR_MAX) begin
      prod_d = ACC_MAX;
    end else if (rnd_shift < PR_MIN) begin
      prod_d = ACC_MIN;
    end else begin
      prod_d = rnd_shift[ACC_WIDTH-1:0];
    end
  end

  // Saturating add or subtract.
  assign x_op = (uop.x_sel == X_PROD) ? prod_q : acc_q;

  always_comb begin
    unique case (uop.y_sel)
      Y_PREV2_R: y_op = prev2_r_q;
      Y_PREV2_I: y_op = prev2_i_q;
      Y_SMP_R:   y_op = ACC_WIDTH'(smp_re_q);
      Y_SMP_I:   y_op = ACC_WIDTH'(smp_im_q);
      Y_PROD:    y_op = prod_q;
      default:   y_op = '0;
    endcase
  end

  assign alu_sum = uop.sub ? (SW'(x_op) - SW'(y_op)) : (SW'(x_op) + SW'(y_op));

  always_comb begin
    if (alu_sum > SUM_MAX) begin
      alu_res = ACC_MAX;
    end else if (alu_sum < SUM_MIN) begin
      alu_res = ACC_MIN;
    end else begin
      alu_res = alu_sum[ACC_WIDTH-1:0];
    end
  end

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= COS_RESET;
      sin_q <= SIN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_COS) begin
        cos_q <= cfg_data_i;
      end else begin
        sin_q <= cfg_data_i;
      end
    end
  end

  // Lane state: advance after the recurrence, clear after a bin is formed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_r_q  <= '0;
      prev2_r_q <= '0;
      prev_i_q  <= '0;
      prev2_i_q <= '0;
    end else if (cmd_i.exec && (uop.op == OP_SHIFT)) begin
      prev2_r_q <= prev_r_q;
      prev_r_q  <= nr_q;
      prev2_i_q <= prev_i_q;
      prev_i_q  <= ni_q;
    end else if (cmd_i.exec && (uop.op == OP_CLEAR)) begin
      prev_r_q  <= '0;
      prev2_r_q <= '0;
      prev_i_q  <= '0;
      prev2_i_q <= '0;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_re_q <= sample_re_i;
      smp_im_q <= sample_im_i;
    end
    if (cmd_i.exec) begin
      unique case (uop.op)
        OP_MUL_LO: pp_lo_q <= pp_lo_d;
        OP_MUL_HI: pp_hi_q <= pp_hi_d;
        OP_RND:    prod_q  <= prod_d;
        OP_ALU: begin
          unique case (uop.dst)
            D_ACC:   acc_q      <= alu_res;
            D_NR:    nr_q       <= alu_res;
            D_NI:    ni_q       <= alu_res;
            D_RE:    bin_real_q <= alu_res;
            D_IM:    bin_imag_q <= alu_res;
            default: acc_q      <= acc_q;
          endcase
        end
        default: pp_lo_q <= pp_lo_q;
      endcase
    end
  end

endmodule

// ----- tb/tb_goertzel_single_bin_complex_unit.sv -----
// Self-checking testbench for the single-bin complex Goertzel unit.
module tb_goertzel_single_bin_complex_unit;
  import gsbc_pkg::*;

  localparam int SMP_W        = 16;
  localparam int ACC_W        = 48;
  localparam int N_PHASES     = 9;
  localparam int ITEMS_PHASE  = 180;
  localparam int SETTLE_CYC   = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam longint ACC_MAX  = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN  = -ACC_MAX - 1;

  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } bin_t;

  // One directed sample; the bin is typed in only where it is obvious.
  typedef struct packed {
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    logic                    last;
    logic                    typed;
    logic signed [ACC_W-1:0] want_re;
    logic signed [ACC_W-1:0] want_im;
  } dir_row_t;

  // With the reset coefficients (cos 1.0, sin 0.0) a one-sample block returns the
  // sample itself, so those bins are typed in. Longer blocks use the predictor.
  localparam dir_row_t DIR_ROWS [16] = '{
    '{0,      0,      1'b1, 1'b1, 0,      0},
    '{32767,  -32768, 1'b1, 1'b1, 32767,  -32768},
    '{-32768, 32767,  1'b1, 1'b1, -32768, 32767},
    '{-1,     1,      1'b1, 1'b1, -1,     1},
    '{21845,  -21846, 1'b1, 1'b1, 21845,  -21846},
    '{-21846, 21845,  1'b1, 1'b1, -21846, 21845},
    '{32767,  32767,  1'b0, 1'b0, 0,      0},
    '{32767,  32767,  1'b0, 1'b0, 0,      0},
    '{32767,  32767,  1'b0, 1'b0, 0,      0},
    '{32767,  32767,  1'b1, 1'b0, 0,      0},
    '{-32768, -32768, 1'b0, 1'b0, 0,      0},
    '{-32768, 0,      1'b0, 1'b0, 0,      0},
    '{-32768, -32768, 1'b1, 1'b0, 0,      0},
    '{1,      -1,     1'b0, 1'b0, 0,      0},
    '{100,    -200,   1'b0, 1'b0, 0,      0},
    '{-300,   400,    1'b1, 1'b0, 0,      0}
  };

  // Coefficient pairs of the fixed phases: the nominal extremes, a 45 degree bin,
  // and the full 18-bit extremes that make the recurrence diverge and saturate.
  localparam int COS_SET [6] = '{65536, -65536, 0, 46341, 131071, -131072};
  localparam int SIN_SET [6] = '{0, 65536, -65536, -46341, -131072, 131071};

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [COEF_WIDTH-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic signed [SMP_W-1:0] sample_re_i;
  logic signed [SMP_W-1:0] sample_im_i;
  logic                   last_sample_i;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [ACC_W-1:0] bin_real_o;
  logic signed [ACC_W-1:0] bin_imag_o;

  // Predictor state: coefficients and both lanes of the recurrence.
  longint coef_cos = 65536;
  longint coef_sin = 0;
  longint lane_r1 = 0, lane_r2 = 0, lane_i1 = 0, lane_i2 = 0;

  bin_t   bin_q [$];
  int     err_cnt   = 0;
  int     cycle_cnt = 0;
  int     burst_left = 0;
  int     rdy_left   = 0;
  bit     vld_q      = 1'b0;

  goertzel_single_bin_complex_unit #(
    .SAMPLE_WIDTH(SMP_W),
    .ACC_WIDTH   (ACC_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_re_i  (sample_re_i),
    .sample_im_i  (sample_im_i),
    .last_sample_i(last_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bin_real_o   (bin_real_o),
    .bin_imag_o   (bin_imag_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Saturating helpers; all operands lie in the accumulator range, so 64 bits suffice.
  function automatic longint clamp_acc(longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clamp_acc(a + b);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clamp_acc(a - b);
  endfunction

  // Product scaled by 2^-sh, rounded half up (floor after adding one half), saturated.
  function automatic longint mul_rnd(longint a, longint c, int sh);
    logic signed [95:0] prod;
    prod = 96'(a) * 96'(c);
    prod = prod + (96'sd1 <<< (sh - 1));
    prod = prod >>> sh;
    if (prod > 96'(ACC_MAX)) return ACC_MAX;
    if (prod < 96'(ACC_MIN)) return ACC_MIN;
    return longint'(prod);
  endfunction

  // Advances both lanes by one sample; on the last sample forms the bin and clears.
  function automatic bit goertzel_step(input longint xr, input longint xi, input bit last,
                                       output bin_t b);
    longint nr, ni, re, im;
    nr = add_sat(sub_sat(mul_rnd(lane_r1, coef_cos, FB_SHIFT), lane_r2), xr);
    ni = add_sat(sub_sat(mul_rnd(lane_i1, coef_cos, FB_SHIFT), lane_i2), xi);
    lane_r2 = lane_r1;
    lane_r1 = nr;
    lane_i2 = lane_i1;
    lane_i1 = ni;
    b = '0;
    if (!last) return 1'b0;
    re = sub_sat(sub_sat(mul_rnd(lane_r1, coef_cos, OUT_SHIFT), lane_r2),
                 mul_rnd(lane_i1, coef_sin, OUT_SHIFT));
    im = sub_sat(add_sat(mul_rnd(lane_r1, coef_sin, OUT_SHIFT),
                         mul_rnd(lane_i1, coef_cos, OUT_SHIFT)), lane_i2);
    b.re = re[ACC_W-1:0];
    b.im = im[ACC_W-1:0];
    lane_r1 = 0;
    lane_r2 = 0;
    lane_i1 = 0;
    lane_i2 = 0;
    return 1'b1;
  endfunction

  // Extremes and small values are favored over plain random samples.
  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SMP_W'(int'($urandom_range(0, 32)) - 16);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic int pick_block_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(13, 48);
    return $urandom_range(1, 12);
  endfunction

  // Both coefficient registers are written, the cosine register first and then the sine register.
  task automatic set_coefs(input logic [COEF_WIDTH-1:0] c, input logic [COEF_WIDTH-1:0] s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COS;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SIN;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    coef_cos = longint'($signed(c));
    coef_sin = longint'($signed(s));
  endtask

  task automatic drop_valid();
    if (vld_q) begin
      in_valid_i <= 1'b0;
      vld_q = 1'b0;
    end
  endtask

  // Presents one sample, waits for its transfer and records the predicted bin.
  task automatic send_sample(input logic signed [SMP_W-1:0] re,
                             input logic signed [SMP_W-1:0] im,
                             input bit last, input bit typed, input bin_t typed_bin);
    bin_t b;
    in_valid_i    <= 1'b1;
    vld_q = 1'b1;
    sample_re_i   <= re;
    sample_im_i   <= im;
    last_sample_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (goertzel_step(re, im, last, b)) bin_q.push_back(typed ? typed_bin : b);
  endtask

  // Sender works in bursts of random length separated by random gaps.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      drop_valid();
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Holds the sender until every pending bin has been taken.
  task automatic drain();
    drop_valid();
    while (bin_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Main stimulus: reset, directed table, then random blocks under several settings.
  initial begin
    int   n_items;
    int   blk_len;
    bin_t tb_bin;
    logic [COEF_WIDTH-1:0] c_val, s_val;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_COS;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    sample_re_i   = '0;
    sample_im_i   = '0;
    last_sample_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      tb_bin.re = DIR_ROWS[i].want_re;
      tb_bin.im = DIR_ROWS[i].want_im;
      send_sample(DIR_ROWS[i].re, DIR_ROWS[i].im, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                  tb_bin);
      pace();
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 6) begin
        c_val = COEF_WIDTH'(COS_SET[ph]);
        s_val = COEF_WIDTH'(SIN_SET[ph]);
      end else if (ph < 8) begin
        c_val = COEF_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
        s_val = COEF_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
      end else begin
        c_val = COEF_WIDTH'($urandom);
        s_val = COEF_WIDTH'($urandom);
      end
      set_coefs(c_val, s_val);
      n_items = 0;
      while (n_items < ITEMS_PHASE) begin
        blk_len = pick_block_len();
        for (int k = 0; k < blk_len; k++) begin
          send_sample(pick_sample(), pick_sample(), k == blk_len - 1, 1'b0, '0);
          pace();
          n_items++;
        end
        // Now and then let the unit run dry in the middle of a phase.
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver alternates ready stretches, short random stalls and long stalls.
  always @(posedge clk_i) begin
    int pick;
    if (rdy_left > 0) begin
      rdy_left <= rdy_left - 1;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        out_ready_i <= 1'b1;
        rdy_left    <= $urandom_range(0, 30);
      end else if (pick < 8) begin
        out_ready_i <= ($urandom_range(0, 1) == 1);
        rdy_left    <= $urandom_range(0, 8);
      end else begin
        out_ready_i <= 1'b0;
        rdy_left    <= $urandom_range(20, 40);
      end
    end
  end

  // Each bin transfer is checked against the oldest predicted bin.
  always @(posedge clk_i) begin
    bin_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bin_q.size() == 0) begin
        $error("bin with none pending: bin_real %0d bin_imag %0d", bin_real_o, bin_imag_o);
        err_cnt++;
      end else begin
        want = bin_q.pop_front();
        if (bin_real_o !== want.re) begin
          $error("bin_real: expected %0d, actual %0d", want.re, bin_real_o);
          err_cnt++;
        end
        if (bin_imag_o !== want.im) begin
          $error("bin_imag: expected %0d, actual %0d", want.im, bin_imag_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
